>>> src/smfd_pkg.sv
package smfd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned TEMP_W = 15;
    localparam int unsigned HUM_W  = 14;
    localparam int unsigned MASK_W = 3;
    localparam int unsigned IDX_W  = 4;
    localparam int unsigned PROD_W = 31;

    // Byte positions within a reply; IDX_IDLE means no reply in progress.
    localparam logic [IDX_W-1:0] IDX_CO2_MSB  = 4'd0;
    localparam logic [IDX_W-1:0] IDX_CO2_LSB  = 4'd1;
    localparam logic [IDX_W-1:0] IDX_CO2_CRC  = 4'd2;
    localparam logic [IDX_W-1:0] IDX_TEMP_MSB = 4'd3;
    localparam logic [IDX_W-1:0] IDX_TEMP_LSB = 4'd4;
    localparam logic [IDX_W-1:0] IDX_TEMP_CRC = 4'd5;
    localparam logic [IDX_W-1:0] IDX_HUM_MSB  = 4'd6;
    localparam logic [IDX_W-1:0] IDX_HUM_LSB  = 4'd7;
    localparam logic [IDX_W-1:0] IDX_HUM_CRC  = 4'd8;
    localparam logic [IDX_W-1:0] IDX_IDLE     = 4'd9;

    // Configuration register indexes
    localparam logic REG_CRC_INIT = 1'b0;
    localparam logic REG_CRC_POLY = 1'b1;

    localparam logic [BYTE_W-1:0] CRC_INIT_RST = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY_RST = 8'h31;

    localparam logic [TEMP_W-1:0] TEMP_SCALE  = 15'd17500;
    localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd4500;
    localparam logic [HUM_W-1:0]  HUM_SCALE   = 14'd10000;
    localparam logic [31:0]       FULL_SCALE  = 32'd65535;

    localparam int unsigned ERR_CO2  = 0;
    localparam int unsigned ERR_TEMP = 1;
    localparam int unsigned ERR_HUM  = 2;

    // MSB-first CRC-8 over one byte, no final XOR.
    function automatic logic [BYTE_W-1:0] crc8_update(
        input logic [BYTE_W-1:0] acc,
        input logic [BYTE_W-1:0] data,
        input logic [BYTE_W-1:0] poly
    );
        logic [BYTE_W-1:0] c;
        c = acc ^ data;
        for (int k = 0; k < BYTE_W; k++)
        begin
            c = c[BYTE_W-1] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

    // floor(x / 65535): estimate that is low by at most one, then one correction.
    function automatic logic [WORD_W-1:0] div_full_scale(input logic [PROD_W-1:0] x);
        logic [31:0]       sum;
        logic [WORD_W-1:0] q;
        logic [31:0]       rem;
        sum = {1'b0, x} + 32'(x[PROD_W-1:WORD_W]);
        q   = sum[31:WORD_W];
        rem = {1'b0, x} - {q, 16'h0000} + 32'(q);
        if (rem >= FULL_SCALE)
        begin
            q = q + 16'd1;
        end
        return q;
    endfunction

endpackage

>>> src/smfd_channels.sv
interface smfd_in_if;
    import smfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_start;

    modport source (output valid, rx_byte, frame_start, input ready);
    modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

interface smfd_out_if;
    import smfd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [WORD_W-1:0]        co2_ppm;
    logic signed [TEMP_W-1:0] temp_centi;
    logic [HUM_W-1:0]         humidity_centi;
    logic [MASK_W-1:0]        crc_error_mask;

    modport source (output valid, co2_ppm, temp_centi, humidity_centi, crc_error_mask,
                    input ready);
    modport sink   (input valid, co2_ppm, temp_centi, humidity_centi, crc_error_mask,
                     output ready);
endinterface

>>> src/sensor_measurement_frame_decoder.sv
// Measurement reply decoder. Bytes of a nine-byte reply (three words, each sent as
// MSB, LSB, CRC-8) enter on the rx channel, one transaction per byte, at up to one
// byte every clock. frame_start on a byte makes it byte 0 of a new reply and clears
// the error mask; bytes without frame_start while no reply is open are dropped.
// Each word is checked with an MSB-first CRC-8 (crc_init at paddr 0, crc_poly at
// paddr 4, no final XOR). The ninth byte yields one result transaction on res: the
// raw CO2 word, temperature in 0.01 degC (-4500 + floor(raw*17500/65535)), humidity
// in 0.01 %RH (floor(raw*10000/65535)) and a per-word CRC mismatch mask. A result
// reaches res through the scale multiplier register and then the divide-by-65535
// correction into the output register. Both stages hold a result each, so rx stays
// ready unless both are full and res is stalled. Write configuration while no
// transaction is in flight; inside a reply crc_init takes effect at the next word's
// MSB and crc_poly at the next MSB or LSB byte.
module sensor_measurement_frame_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    smfd_in_if.sink                       rx,
    smfd_out_if.source                    res
);
    import smfd_pkg::*;

    // Configuration
    logic [BYTE_W-1:0] crc_init_reg;
    logic [BYTE_W-1:0] crc_poly_reg;
    logic              cfg_write;

    // Reply assembly state
    logic [IDX_W-1:0]  byte_index_reg, byte_index_next;
    logic [BYTE_W-1:0] crc_acc_reg,    crc_acc_next;
    logic [BYTE_W-1:0] msb_hold_reg,   msb_hold_next;
    logic [BYTE_W-1:0] lsb_hold_reg,   lsb_hold_next;
    logic [WORD_W-1:0] co2_hold_reg,   co2_hold_next;
    logic [PROD_W-1:0] temp_prod_reg,  temp_prod_next;
    logic [MASK_W-1:0] error_bits_reg, error_bits_next;

    // Product stage
    logic              s1_valid_reg;
    logic [WORD_W-1:0] s1_co2_reg;
    logic [PROD_W-1:0] s1_temp_prod_reg;
    logic [PROD_W-1:0] s1_hum_prod_reg;
    logic [MASK_W-1:0] s1_mask_reg;

    // Output register
    logic                     out_valid_reg;
    logic [WORD_W-1:0]        out_co2_reg;
    logic signed [TEMP_W-1:0] out_temp_reg;
    logic [HUM_W-1:0]         out_hum_reg;
    logic [MASK_W-1:0]        out_mask_reg;

    logic              out_free;
    logic              s1_free;
    logic              rx_fire;
    logic              frame_done;
    logic [IDX_W-1:0]  idx_eff;
    logic [MASK_W-1:0] err_eff;
    logic [WORD_W-1:0] word_value;
    logic              crc_bad;
    logic [WORD_W-1:0] temp_q;
    logic [WORD_W-1:0] hum_q;

    // ---------------------------------------------------------------- APB port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    // Byte lanes below bit 2 do not select a register.
    assign prdata    = (paddr[2] == REG_CRC_POLY) ? 32'(crc_poly_reg) : 32'(crc_init_reg);

    // ---------------------------------------------------------------- handshake
    // Advance the pipeline when the output register is empty or being taken.
    assign out_free = !out_valid_reg || res.ready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign rx.ready = s1_free;
    assign rx_fire  = rx.valid && rx.ready;

    // ---------------------------------------------------------------- byte walk
    assign idx_eff    = rx.frame_start ? IDX_CO2_MSB : byte_index_reg;
    assign err_eff    = rx.frame_start ? '0 : error_bits_reg;
    assign word_value = {msb_hold_reg, lsb_hold_reg};
    assign crc_bad    = (crc_acc_reg != rx.rx_byte);
    assign frame_done = rx_fire && (idx_eff == IDX_HUM_CRC);

    always_comb
    begin
        byte_index_next = byte_index_reg;
        crc_acc_next    = crc_acc_reg;
        msb_hold_next   = msb_hold_reg;
        lsb_hold_next   = lsb_hold_reg;
        co2_hold_next   = co2_hold_reg;
        temp_prod_next  = temp_prod_reg;
        error_bits_next = error_bits_reg;
        if (rx_fire)
        begin
            byte_index_next = idx_eff + 4'd1;
            error_bits_next = err_eff;
            unique case (idx_eff)
                IDX_CO2_MSB, IDX_TEMP_MSB, IDX_HUM_MSB:
                begin
                    msb_hold_next = rx.rx_byte;
                    crc_acc_next  = crc8_update(crc_init_reg, rx.rx_byte, crc_poly_reg);
                end
                IDX_CO2_LSB, IDX_TEMP_LSB, IDX_HUM_LSB:
                begin
                    lsb_hold_next = rx.rx_byte;
                    crc_acc_next  = crc8_update(crc_acc_reg, rx.rx_byte, crc_poly_reg);
                end
                IDX_CO2_CRC:
                begin
                    co2_hold_next             = word_value;
                    error_bits_next[ERR_CO2]  = err_eff[ERR_CO2] | crc_bad;
                end
                IDX_TEMP_CRC:
                begin
                    // Scale now; the divide happens after the ninth byte.
                    temp_prod_next            = PROD_W'(word_value * TEMP_SCALE);
                    error_bits_next[ERR_TEMP] = err_eff[ERR_TEMP] | crc_bad;
                end
                IDX_HUM_CRC:
                begin
                    byte_index_next           = IDX_IDLE;
                    error_bits_next[ERR_HUM]  = err_eff[ERR_HUM] | crc_bad;
                end
                default:
                begin
                    // Idle: drop the byte.
                    byte_index_next = byte_index_reg;
                    error_bits_next = error_bits_reg;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- scaling
    assign temp_q = div_full_scale(s1_temp_prod_reg);
    assign hum_q  = div_full_scale(s1_hum_prod_reg);

    // ---------------------------------------------------------------- control regs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_init_reg   <= CRC_INIT_RST;
            crc_poly_reg   <= CRC_POLY_RST;
            byte_index_reg <= IDX_IDLE;
            error_bits_reg <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (paddr[2])
                    REG_CRC_INIT: crc_init_reg <= pwdata[BYTE_W-1:0];
                    REG_CRC_POLY: crc_poly_reg <= pwdata[BYTE_W-1:0];
                    default:      crc_init_reg <= crc_init_reg;
                endcase
            end
            byte_index_reg <= byte_index_next;
            error_bits_reg <= error_bits_next;
            if (frame_done)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // ---------------------------------------------------------------- payload regs
    always_ff @(posedge clk)
    begin
        crc_acc_reg   <= crc_acc_next;
        msb_hold_reg  <= msb_hold_next;
        lsb_hold_reg  <= lsb_hold_next;
        co2_hold_reg  <= co2_hold_next;
        temp_prod_reg <= temp_prod_next;
        if (frame_done)
        begin
            s1_co2_reg       <= co2_hold_reg;
            s1_temp_prod_reg <= temp_prod_reg;
            s1_hum_prod_reg  <= PROD_W'({msb_hold_reg, lsb_hold_reg} * HUM_SCALE);
            s1_mask_reg      <= error_bits_next;
        end
        if (out_free && s1_valid_reg)
        begin
            out_co2_reg  <= s1_co2_reg;
            // Quotient is at most 17500, so it fits the 15-bit field before the offset.
            out_temp_reg <= $signed(temp_q[TEMP_W-1:0] - TEMP_OFFSET);
            out_hum_reg  <= hum_q[HUM_W-1:0];
            out_mask_reg <= s1_mask_reg;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.co2_ppm        = out_co2_reg;
    assign res.temp_centi     = out_temp_reg;
    assign res.humidity_centi = out_hum_reg;
    assign res.crc_error_mask = out_mask_reg;

    // ---------------------------------------------------------------- checks
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg <= IDX_IDLE)
        else $error("byte index beyond idle");

    a_s1_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s1_valid_reg) |-> $past(rx_fire))
        else $error("product stage loaded without a byte");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> (s1_valid_reg && out_valid_reg && !res.ready))
        else $error("rx stalled with room in the pipeline");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_hum_reg <= HUM_SCALE))
        else $error("humidity beyond full scale");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_temp_reg >= -$signed(TEMP_OFFSET)
                           && out_temp_reg <= 15'sd13000))
        else $error("temperature out of range");

endmodule

>>> tb/sv/sensor_measurement_frame_decoder_tb.sv
module sensor_measurement_frame_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smfd_pkg::*;

    // Run shaping
    localparam int unsigned BYTE_GOAL   = 2000;             // reply bytes in the random part
    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_BYTES = BYTE_GOAL / PHASES;
    localparam int unsigned LONG_HOLD   = 300;              // cycles the result side holds off
    localparam int unsigned TAIL_CYCLES = 4;                // pipeline depth plus margin
    localparam int unsigned STALL_LIMIT = 2000;             // cycles with no transaction at all

    // Scaling of the two converted words, in hundredths
    localparam longint unsigned TEMP_SPAN  = 17500;
    localparam longint unsigned HUM_SPAN   = 10000;
    localparam longint unsigned RAW_FULL   = 65535;
    localparam int              TEMP_FLOOR = 4500;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              start;
    } rx_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]        co2;
        logic signed [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]         hum;
        logic [MASK_W-1:0]        mask;
    } reading_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Configuration port, driven only by the register write task
    logic        apb_sel    = 1'b0;
    logic        apb_enable = 1'b0;
    logic        apb_write  = 1'b0;
    logic [2:0]  apb_addr   = '0;
    logic [31:0] apb_wdata  = '0;
    logic [31:0] apb_rdata;
    logic        apb_ready;

    // Channel drive values; each has exactly one procedural writer
    logic              send_valid = 1'b0;
    logic [BYTE_W-1:0] send_byte  = '0;
    logic              send_start = 1'b0;
    logic              take_ready = 1'b0;

    smfd_in_if  rx_ch ();
    smfd_out_if res_ch ();

    assign rx_ch.valid       = send_valid;
    assign rx_ch.rx_byte     = send_byte;
    assign rx_ch.frame_start = send_start;
    assign res_ch.ready      = take_ready;

    sensor_measurement_frame_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (apb_sel),
        .penable (apb_enable),
        .pwrite  (apb_write),
        .paddr   (apb_addr),
        .pwdata  (apb_wdata),
        .prdata  (apb_rdata),
        .pready  (apb_ready),
        .rx      (rx_ch),
        .res     (res_ch)
    );

    // Invert the clock every half period (4 ns period).
    always #2 clk = ~clk;

    // Bytes waiting to be offered, and readings the decoder still owes us
    rx_item_t rx_pending[$];
    reading_t readings_due[$];
    rx_item_t next_item;

    // Handshake flags, sampled at the rising edge, consumed at the falling edge
    bit rx_fire  = 1'b0;
    bit res_fire = 1'b0;

    // Idle shaping; the gap limits and hold requests are set per phase by the stimulus process
    int unsigned send_gap_max = 0;
    int unsigned recv_gap_max = 0;
    int unsigned send_gap     = 0;
    int unsigned recv_wait    = 0;
    int unsigned hold_left    = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_served  = 0;

    // Our own copy of the decoder: configuration plus reply-tracking state
    logic [BYTE_W-1:0] cfg_init = CRC_INIT_RST;
    logic [BYTE_W-1:0] cfg_poly = CRC_POLY_RST;
    logic [IDX_W-1:0]  frame_pos = IDX_IDLE;
    logic [BYTE_W-1:0] crc_run   = '0;
    logic [BYTE_W-1:0] msb_byte  = '0;
    logic [BYTE_W-1:0] lsb_byte  = '0;
    logic [WORD_W-1:0] co2_word  = '0;
    logic [WORD_W-1:0] temp_word = '0;
    logic [MASK_W-1:0] bad_words = '0;

    // Bookkeeping
    int unsigned mismatches     = 0;
    int unsigned frame_bytes    = 0;
    int unsigned dropped_bytes  = 0;
    int unsigned readings_seen  = 0;
    int unsigned crc_fail_reads = 0;
    int unsigned reg_writes     = 0;
    int unsigned stall_cycles   = 0;

    task automatic flag_error(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // CRC-8, MSB first, shifting one message bit at a time into the top of the register.
    function automatic logic [BYTE_W-1:0] crc_feed(input logic [BYTE_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] r;
        logic              fb;
        r = acc;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            fb = r[BYTE_W-1] ^ data[i];
            r  = {r[BYTE_W-2:0], 1'b0};
            if (fb)
                r = r ^ cfg_poly;
        end
        return r;
    endfunction

    // Advance the reply tracker by one accepted byte; raise done when the ninth
    // byte completes a reading.
    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic start,
                               output bit done, output reading_t r);
        longint unsigned t;
        longint unsigned h;
        done = 1'b0;
        r    = '0;
        if (start)
        begin
            frame_pos = IDX_CO2_MSB;
            bad_words = '0;
        end
        if (frame_pos >= IDX_IDLE)
        begin
            dropped_bytes++;
            return;
        end
        case (frame_pos)
            IDX_CO2_MSB, IDX_TEMP_MSB, IDX_HUM_MSB:
            begin
                // each word restarts the CRC from the init value in force right now
                msb_byte  = b;
                crc_run   = crc_feed(cfg_init, b);
                frame_pos = frame_pos + 1'b1;
            end
            IDX_CO2_LSB, IDX_TEMP_LSB, IDX_HUM_LSB:
            begin
                lsb_byte  = b;
                crc_run   = crc_feed(crc_run, b);
                frame_pos = frame_pos + 1'b1;
            end
            IDX_CO2_CRC:
            begin
                if (crc_run != b)
                    bad_words[ERR_CO2] = 1'b1;
                co2_word  = {msb_byte, lsb_byte};
                frame_pos = frame_pos + 1'b1;
            end
            IDX_TEMP_CRC:
            begin
                if (crc_run != b)
                    bad_words[ERR_TEMP] = 1'b1;
                temp_word = {msb_byte, lsb_byte};
                frame_pos = frame_pos + 1'b1;
            end
            default:
            begin
                if (crc_run != b)
                    bad_words[ERR_HUM] = 1'b1;
                frame_pos = IDX_IDLE;
                t = (longint'(temp_word) * TEMP_SPAN) / RAW_FULL;
                h = (longint'({msb_byte, lsb_byte}) * HUM_SPAN) / RAW_FULL;
                r.co2  = co2_word;
                r.temp = TEMP_W'(int'(t) - TEMP_FLOOR);
                r.hum  = HUM_W'(h);
                r.mask = bad_words;
                done   = 1'b1;
            end
        endcase
    endtask

    // Compare the reading on res against the oldest one owed.
    task automatic check_reading();
        reading_t want;
        if (readings_due.size() == 0)
        begin
            flag_error($sformatf("reading with none due: co2 %0d temp %0d hum %0d mask %0b",
                                 res_ch.co2_ppm, res_ch.temp_centi, res_ch.humidity_centi,
                                 res_ch.crc_error_mask));
            return;
        end
        want = readings_due.pop_front();
        readings_seen++;
        if (want.mask != '0)
            crc_fail_reads++;
        if (res_ch.co2_ppm !== want.co2)
            flag_error($sformatf("co2_ppm got %0d want %0d", res_ch.co2_ppm, want.co2));
        if (res_ch.temp_centi !== want.temp)
            flag_error($sformatf("temp_centi got %0d want %0d", res_ch.temp_centi, want.temp));
        if (res_ch.humidity_centi !== want.hum)
            flag_error($sformatf("humidity_centi got %0d want %0d",
                                 res_ch.humidity_centi, want.hum));
        if (res_ch.crc_error_mask !== want.mask)
            flag_error($sformatf("crc_error_mask got %b want %b",
                                 res_ch.crc_error_mask, want.mask));
    endtask

    // Monitor: sample both handshakes at the rising edge, feed the predictor with
    // every accepted byte, check every accepted reading, and run the watchdog.
    always @(posedge clk)
    begin
        bit       made;
        reading_t predicted;
        rx_fire  = rst_n && rx_ch.valid && rx_ch.ready;
        res_fire = rst_n && res_ch.valid && res_ch.ready;
        if (rx_fire)
        begin
            decode_byte(rx_ch.rx_byte, rx_ch.frame_start, made, predicted);
            if (made)
                readings_due.push_back(predicted);
        end
        if (res_fire)
            check_reading();
        if (rx_fire || res_fire || !rst_n)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, stall_cycles);
            $display("sensor_measurement_frame_decoder_tb: errors");
            $finish;
        end
    end

    // Byte driver: hold the current byte until its transaction completes, then
    // draw an idle gap and offer the next pending byte once the gap has run out.
    always @(negedge clk)
    begin
        if (rst_n && (rx_fire || !send_valid))
        begin
            if (rx_fire)
                send_gap = $urandom_range(0, send_gap_max);
            if (send_gap == 0 && rx_pending.size() != 0)
            begin
                next_item = rx_pending.pop_front();
                send_valid <= 1'b1;
                send_byte  <= next_item.data;
                send_start <= next_item.start;
            end
            else
            begin
                send_valid <= 1'b0;
                if (send_gap != 0)
                    send_gap--;
            end
        end
    end

    // Result receiver: stall a random number of cycles after each reading, and
    // serve long hold-off requests by dropping ready while the LONG_HOLD countdown runs.
    always @(negedge clk)
    begin
        if (res_fire)
            recv_wait = $urandom_range(0, recv_gap_max);
        if (hold_requests != holds_served)
        begin
            hold_left = LONG_HOLD;
            holds_served++;
        end
        if (hold_left != 0)
        begin
            take_ready <= 1'b0;
            hold_left--;
        end
        else if (recv_wait != 0)
        begin
            take_ready <= 1'b0;
            recv_wait--;
        end
        else
            take_ready <= 1'b1;
    end

    // Write one register over the configuration port: setup cycle, then access
    // cycle; our copy of the register changes at the edge that commits it.
    task automatic write_register(input logic reg_sel, input logic [BYTE_W-1:0] value);
        @(negedge clk);
        apb_sel    <= 1'b1;
        apb_enable <= 1'b0;
        apb_write  <= 1'b1;
        apb_addr   <= {reg_sel, 2'b00};
        apb_wdata  <= 32'(value);
        @(negedge clk);
        apb_enable <= 1'b1;
        @(posedge clk);
        while (!apb_ready)
            @(posedge clk);
        if (reg_sel == REG_CRC_INIT)
            cfg_init = value;
        else
            cfg_poly = value;
        reg_writes++;
        @(negedge clk);
        apb_sel    <= 1'b0;
        apb_enable <= 1'b0;
        apb_write  <= 1'b0;
    endtask

    // Wait until every pending byte has been taken and every owed reading has
    // arrived, then let the pipeline settle for bytes that owe nothing.
    task automatic drain();
        while (rx_pending.size() != 0 || send_valid || readings_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic start);
        rx_pending.push_back(rx_item_t'{b, start});
        frame_bytes++;
    endtask

    // Queue MSB, LSB and CRC of one word; corrupt flips the CRC to a wrong value.
    task automatic queue_word(input logic [WORD_W-1:0] w, input logic first,
                              input logic corrupt);
        logic [BYTE_W-1:0] crc;
        crc = crc_feed(crc_feed(cfg_init, w[15:8]), w[7:0]);
        if (corrupt)
            crc = crc ^ 8'($urandom_range(1, 255));
        queue_byte(w[15:8], first);
        queue_byte(w[7:0], 1'b0);
        queue_byte(crc, 1'b0);
    endtask

    task automatic queue_frame(input logic [WORD_W-1:0] co2, input logic [WORD_W-1:0] temp,
                               input logic [WORD_W-1:0] hum, input logic [MASK_W-1:0] corrupt);
        queue_word(co2, 1'b1, corrupt[ERR_CO2]);
        queue_word(temp, 1'b0, corrupt[ERR_TEMP]);
        queue_word(hum, 1'b0, corrupt[ERR_HUM]);
    endtask

    // Bias raw words toward the ends of the range.
    function automatic logic [WORD_W-1:0] pick_word();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return WORD_W'($urandom);
    endfunction

    // Stimulus
    initial
    begin
        logic [BYTE_W-1:0] init_plan [PHASES];
        logic [BYTE_W-1:0] poly_plan [PHASES];
        int unsigned       send_plan [PHASES];
        int unsigned       recv_plan [PHASES];
        int unsigned       phase_goal;
        int unsigned       kind;
        int unsigned       run_len;
        bit                paused;

        init_plan = '{8'h00, 8'hFF, 8'h00, 8'h5A, 8'hFF, 8'hC3, 8'h00, 8'hFF};
        poly_plan = '{8'h31, 8'h00, 8'hFF, 8'h07, 8'h31, 8'h9B, 8'h01, 8'h80};
        send_plan = '{7, 0, 0, 7, 3, 0, 7, 7};
        recv_plan = '{7, 0, 7, 0, 7, 0, 3, 7};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: bytes without a start mark while idle after reset are dropped.
        rx_pending.push_back(rx_item_t'{8'h00, 1'b0});
        rx_pending.push_back(rx_item_t'{8'hFF, 1'b0});

        // Minimum CO2 and temperature, full-scale humidity, all CRCs good. Change
        // crc_init between the first and second word: the new value applies from
        // the next MSB on.
        queue_word(16'h0000, 1'b1, 1'b0);
        drain();
        write_register(REG_CRC_INIT, 8'h00);
        queue_word(16'h0000, 1'b0, 1'b0);
        queue_word(16'hFFFF, 1'b0, 1'b0);

        // Start mark in the middle of a reply restarts it; the new reply has every
        // raw word at its far end and every CRC wrong.
        queue_word(16'hFFFF, 1'b1, 1'b0);
        queue_byte(8'h12, 1'b0);
        queue_frame(16'hFFFF, 16'hFFFF, 16'h0000, 3'b111);

        // A byte after the ninth, with no start mark, is dropped.
        rx_pending.push_back(rx_item_t'{8'h5A, 1'b0});
        drain();

        // Random part: each phase runs under its own CRC setting and idle profile.
        frame_bytes = 0;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            write_register(REG_CRC_INIT,
                           (phase % 3 == 2) ? BYTE_W'($urandom) : init_plan[phase]);
            write_register(REG_CRC_POLY,
                           (phase % 4 == 3) ? BYTE_W'($urandom) : poly_plan[phase]);
            send_gap_max = send_plan[phase];
            recv_gap_max = recv_plan[phase];
            // In one phase hold off the result side while bytes keep coming, so
            // the decoder fills up and stalls its byte input.
            if (phase == 2)
                hold_requests++;
            phase_goal = frame_bytes + PHASE_BYTES;
            paused     = 1'b0;
            while (frame_bytes < phase_goal)
            begin
                // Midway, stop offering until every owed reading is back.
                if (!paused && frame_bytes + PHASE_BYTES / 2 >= phase_goal)
                begin
                    drain();
                    paused = 1'b1;
                end
                kind = $urandom_range(0, 99);
                if (kind < 78)
                begin
                    queue_frame(pick_word(), pick_word(), pick_word(),
                                {$urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                                 $urandom_range(0, 9) == 0});
                end
                else if (kind < 88)
                begin
                    // reply cut short; whatever follows either restarts or continues it
                    run_len = $urandom_range(1, 8);
                    for (int i = 0; i < run_len; i++)
                        queue_byte(BYTE_W'($urandom), i == 0);
                end
                else if (kind < 94)
                begin
                    // raw bytes with stray start marks
                    for (int i = 0; i < 9; i++)
                        queue_byte(BYTE_W'($urandom), (i == 0) || ($urandom_range(0, 7) == 0));
                end
                else
                begin
                    // noise without start marks
                    run_len = $urandom_range(1, 4);
                    for (int i = 0; i < run_len; i++)
                        rx_pending.push_back(rx_item_t'{BYTE_W'($urandom), 1'b0});
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d reply bytes, %0d readings checked (%0d with CRC errors)",
                 frame_bytes + 25, readings_seen, crc_fail_reads);
        $display("dropped %0d idle bytes, %0d register writes, %0d long result stall(s)",
                 dropped_bytes, reg_writes, holds_served);
        if (mismatches == 0)
            $display("sensor_measurement_frame_decoder_tb: clean");
        else
            $display("sensor_measurement_frame_decoder_tb: errors");
        $finish;
    end

endmodule
